// ===== design/rbd_pkg.sv =====
// rbd_pkg: shared types and codes for the ring buffer deque.
// Beat structs for both channels, operation and status codes, cell control.
// No dependencies.
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_REAR  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_REAR   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_func                     func;
        logic signed [FIELD_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        t_status                   status;
        logic signed [FIELD_W-1:0] front_value;
        logic signed [FIELD_W-1:0] rear_value;
        logic [COUNT_W-1:0]        count;
    } t_out_beat;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic shift_right;  // push front: everyone moves one toward the rear
        logic shift_left;   // pop front: everyone moves one toward the front
        logic push_rear;    // the first free cell loads the word
    } t_cell_ctrl;

endpackage

// ===== design/ring_buffer_deque.sv =====
// ring_buffer_deque: fixed-capacity double-ended queue built as a row of cells.
// Instantiates rbd_cell (one per slot) and rbd_rear_sel; types from rbd_pkg.
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries one operation per beat:
//   push front, push rear, pop front or pop rear (push carries a word).
//   Output channel o_out_valid / i_out_stall returns exactly one beat per
//   input beat: status (done, full, empty), front word, rear word, count.
//   An empty queue reports all ones for both words.
//   Storage is a row of DEPTH cells; the front word always sits in cell 0,
//   the rear word in cell count-1. Front ops shift the whole row one place;
//   a rear push writes only the first free cell, a rear pop touches no cell.
//   The row updates on the accepting edge; the result register then
//   samples the updated row once it is free to load, which sets o_out_valid.
//   Input stalls from the accept until that sample is taken, so a new item
//   is not accepted before the result of the last one has been formed.
//   Input is accepted while an earlier result still waits downstream.
//   When the receiver stalls, the result register holds; a following item
//   is accepted, then input stalls until that register frees up.
//   Reset clears count and handshake state; cell words are not reset and
//   are never reported before being written.
`timescale 1ns / 1ps

module ring_buffer_deque #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rbd_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rbd_pkg::t_out_beat o_out_beat
);
    import rbd_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    // Handshake and control state
    logic               r_calc;       // row updated, result not yet formed
    logic               r_out_valid;
    t_status            r_status;
    t_out_beat          r_out;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_full;
    logic                  w_empty;
    t_status               w_status;
    t_cell_ctrl            w_ctrl;
    logic [DATA_WIDTH-1:0] w_word;
    logic [DATA_WIDTH-1:0] w_rear;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_taps [DEPTH];

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    // Pushed word keeps its low DATA_WIDTH bits, zero-extended when wider.
    assign w_word = DATA_WIDTH'($unsigned(i_in_beat.value));

    // Decode the operation against the current fill level.
    always_comb begin
        w_status = ST_DONE;
        w_ctrl   = '0;
        n_count  = r_count;
        case (i_in_beat.func)
            FUNC_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.shift_right = w_accept;
                    n_count            = r_count + CNT_W'(1);
                end
            end
            FUNC_PUSH_REAR: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.push_rear = w_accept;
                    n_count          = r_count + CNT_W'(1);
                end
            end
            FUNC_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctrl.shift_left = w_accept;
                    n_count           = r_count - CNT_W'(1);
                end
            end
            FUNC_POP_REAR: begin
                // Rear pop only drops the count; the cell keeps stale data.
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                w_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_calc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_calc  <= 1'b1;
            end else if (r_calc && w_out_free) begin
                r_calc <= 1'b0;
            end
            if (r_calc && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status rides alongside the row update; payload, no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
        end
    end

    // Cell row: cell 0 is the front. Its left neighbor is the pushed word.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = w_word;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        rbd_cell #(
            .IDX        (g),
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_count      (r_count),
            .i_word       (w_word),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .o_data       (w_data[g]),
            .o_rear_tap   (w_taps[g])
        );
    end

    rbd_rear_sel #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_rear_sel (
        .i_taps (w_taps),
        .o_rear (w_rear)
    );

    // Result register: samples the updated row once it is free to load.
    always_ff @(posedge i_clk) begin
        if (r_calc && w_out_free) begin
            r_out.status <= r_status;
            r_out.count  <= COUNT_W'(r_count);
            if (w_empty) begin
                r_out.front_value <= '1;
                r_out.rear_value  <= '1;
            end else begin
                r_out.front_value <= FIELD_W'(w_data[0]);
                r_out.rear_value  <= FIELD_W'(w_rear);
            end
        end
    end

    assign o_in_stall  = r_calc;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count beyond capacity");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_empty && (i_in_beat.func == FUNC_POP_FRONT ||
                                 i_in_beat.func == FUNC_POP_REAR))
        |=> (r_status == ST_EMPTY) && $stable(r_count))
        else $error("pop on empty queue not refused");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && (i_in_beat.func == FUNC_PUSH_FRONT ||
                                i_in_beat.func == FUNC_PUSH_REAR))
        |=> (r_status == ST_FULL) && $stable(r_count))
        else $error("push on full queue not refused");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.count == '0 && DEPTH < 32)
        |-> (o_out_beat.front_value == '1) && (o_out_beat.rear_value == '1))
        else $error("empty result must report all-ones words");

endmodule

// ===== design/rbd_cell.sv =====
// rbd_cell: one word slot of the deque row.
// Takes its neighbors' words on front ops, loads the pushed word on rear push.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_cell #(
    parameter int unsigned IDX        = 0,
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned CNT_W      = 5
) (
    input  logic                    i_clk,
    input  rbd_pkg::t_cell_ctrl     i_ctrl,
    input  logic [CNT_W-1:0]        i_count,
    input  logic [DATA_WIDTH-1:0]   i_word,
    input  logic [DATA_WIDTH-1:0]   i_left_data,
    input  logic [DATA_WIDTH-1:0]   i_right_data,
    output logic [DATA_WIDTH-1:0]   o_data,
    output logic [DATA_WIDTH-1:0]   o_rear_tap
);
    import rbd_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic                  w_first_free;
    logic                  w_is_last;

    assign w_first_free = (i_count == CNT_W'(IDX));
    assign w_is_last    = (i_count == CNT_W'(IDX + 1));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_right) begin
            r_data <= i_left_data;
        end else if (i_ctrl.shift_left) begin
            r_data <= i_right_data;
        end else if (i_ctrl.push_rear && w_first_free) begin
            r_data <= i_word;
        end
    end

    assign o_data     = r_data;
    assign o_rear_tap = w_is_last ? r_data : '0;

endmodule

// ===== design/rbd_rear_sel.sv =====
// rbd_rear_sel: picks the rear word out of the cell row.
// At most one cell drives a nonzero tap, so the pick is a wide OR.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_rear_sel #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic [DATA_WIDTH-1:0] i_taps [DEPTH],
    output logic [DATA_WIDTH-1:0] o_rear
);
    import rbd_pkg::*;

    always_comb begin
        o_rear = '0;
        for (int i = 0; i < DEPTH; i++) begin
            o_rear = o_rear | i_taps[i];
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for ring_buffer_deque (depth 16, 32-bit words).
// Mirrors the deque in a local ring model and checks every result beat.
// Depends on rbd_pkg and ring_buffer_deque from the design folder.
`timescale 1ns / 1ps

module tb_top;
    import rbd_pkg::*;

    localparam int unsigned DEPTH      = 16;
    localparam int unsigned DRAIN_WAIT = 10;
    localparam int unsigned HANG_LIMIT = 2000;  // cycles with no beat on either side

    // ---------------------------------------------------------------------
    // Clock, reset and DUT
    // ---------------------------------------------------------------------
    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;

    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_beat;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ring_buffer_deque #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (32)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (o_out_beat)
    );

    // Beats move on an edge where valid is high and stall is low. Both are
    // sampled before the edge's updates land, so these are race free.
    wire in_fire  = in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !out_stall;

    // ---------------------------------------------------------------------
    // Deque mirror: head points at the front word, tail one past the rear.
    // 4-bit pointers wrap modulo DEPTH on their own.
    // ---------------------------------------------------------------------
    logic [31:0] mirror_ring [DEPTH];
    logic [3:0]  mirror_head = '0;
    logic [3:0]  mirror_tail = '0;
    logic [4:0]  mirror_fill = '0;

    function automatic t_out_beat deque_apply(t_in_beat b);
        t_out_beat r;
        r        = '0;
        r.status = ST_DONE;
        case (b.func)
            FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
                if (mirror_fill == DEPTH) begin
                    r.status = ST_FULL;        // refused, nothing moves
                end else if (b.func == FUNC_PUSH_FRONT) begin
                    mirror_head              = mirror_head - 1'b1;
                    mirror_ring[mirror_head] = b.value;
                    mirror_fill              = mirror_fill + 1'b1;
                end else begin
                    mirror_ring[mirror_tail] = b.value;
                    mirror_tail              = mirror_tail + 1'b1;
                    mirror_fill              = mirror_fill + 1'b1;
                end
            end
            FUNC_POP_FRONT, FUNC_POP_REAR: begin
                if (mirror_fill == 0) begin
                    r.status = ST_EMPTY;       // refused, nothing moves
                end else if (b.func == FUNC_POP_FRONT) begin
                    mirror_head = mirror_head + 1'b1;
                    mirror_fill = mirror_fill - 1'b1;
                end else begin
                    mirror_tail = mirror_tail - 1'b1;
                    mirror_fill = mirror_fill - 1'b1;
                end
            end
        endcase
        r.count = mirror_fill;
        if (mirror_fill == 0) begin
            // empty queue reports all ones on both ends
            r.front_value = '1;
            r.rear_value  = '1;
        end else begin
            r.front_value = mirror_ring[mirror_head];
            r.rear_value  = mirror_ring[mirror_tail - 1'b1];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Shared bench state
    // ---------------------------------------------------------------------
    t_in_beat    op_backlog [$];   // beats waiting to be offered
    t_out_beat   due_results [$];  // predicted result beats, oldest first
    int unsigned src_idle_pct  = 0;
    int unsigned dst_stall_pct = 0;
    int unsigned err_cnt       = 0;
    int unsigned quiet_cycles  = 0;

    // ---------------------------------------------------------------------
    // Driver: offers the next backlog beat, or idles at random. A held beat
    // is never changed or withdrawn while the DUT stalls it.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                due_results.push_back(deque_apply(in_beat));
            end
            if (!in_valid || !o_in_stall) begin
                if (op_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    in_valid <= 1'b1;
                    in_beat  <= op_backlog.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: random back pressure, and a field-by-field check of every
    // accepted result beat against the oldest prediction.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out_beat want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < dst_stall_pct);
            if (out_fire) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result beat with none expected: %p", $time, o_out_beat);
                    err_cnt++;
                end else begin
                    want = due_results.pop_front();
                    if (o_out_beat.status !== want.status) begin
                        $display("%0t: status expected %s got %s", $time,
                                 want.status.name(), o_out_beat.status.name());
                        err_cnt++;
                    end
                    if (o_out_beat.front_value !== want.front_value) begin
                        $display("%0t: front_value expected %h got %h", $time,
                                 want.front_value, o_out_beat.front_value);
                        err_cnt++;
                    end
                    if (o_out_beat.rear_value !== want.rear_value) begin
                        $display("%0t: rear_value expected %h got %h", $time,
                                 want.rear_value, o_out_beat.rear_value);
                        err_cnt++;
                    end
                    if (o_out_beat.count !== want.count) begin
                        $display("%0t: count expected %0d got %0d", $time,
                                 want.count, o_out_beat.count);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog: a correct DUT moves some beat well within the limit.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire || out_fire) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic queue_op(t_func f, logic [31:0] v);
        t_in_beat b;
        b.func  = f;
        b.value = v;
        op_backlog.push_back(b);
    endtask

    // Mostly full-range random words, with the corner words mixed in.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Bursts with a random push/pop bias, so the fill level sweeps between
    // empty and full and both refusal cases keep coming up.
    task automatic queue_random(int unsigned n);
        int unsigned left;
        int unsigned burst;
        int unsigned push_pct;
        left = n;
        while (left > 0) begin
            burst    = $urandom_range(8, 40);
            push_pct = $urandom_range(15, 85);
            if (burst > left) burst = left;
            repeat (burst) begin
                if ($urandom_range(99) < push_pct) begin
                    queue_op($urandom_range(1) ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT,
                             pick_word());
                end else begin
                    // pops carry junk words, the DUT must ignore them
                    queue_op($urandom_range(1) ? FUNC_POP_REAR : FUNC_POP_FRONT, $urandom);
                end
            end
            left -= burst;
        end
    endtask

    // Sender holds off until every prediction has been matched.
    task automatic wait_drained();
        while (op_backlog.size() != 0 || in_valid || due_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase 1: sender idles 27%, receiver stalls 51%.
        src_idle_pct  = 27;
        dst_stall_pct = 51;

        // Directed: pops on an empty queue, front push wrapping the head
        // below zero, extreme words at both ends, then fill to capacity and
        // push into a full queue from either side.
        queue_op(FUNC_POP_FRONT,  32'hDEAD_BEEF);
        queue_op(FUNC_POP_REAR,   32'h1234_5678);
        queue_op(FUNC_PUSH_FRONT, 32'h8000_0000);
        queue_op(FUNC_PUSH_REAR,  32'h7FFF_FFFF);
        queue_op(FUNC_POP_REAR,   32'h0);
        queue_op(FUNC_POP_FRONT,  32'hFFFF_FFFF);
        for (int i = 0; i < DEPTH; i++) begin
            queue_op(i[0] ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT,
                     i[1] ? 32'h5555_5555 + i : 32'hAAAA_AAAA - i);
        end
        queue_op(FUNC_PUSH_FRONT, 32'h0BAD_F00D);
        queue_op(FUNC_PUSH_REAR,  32'hFFFF_FFFF);
        queue_random(200);
        wait_drained();

        // Phase 2: roles swapped.
        src_idle_pct  = 51;
        dst_stall_pct = 27;
        queue_random(200);
        wait_drained();

        // Phase 3: back to back in both directions.
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        queue_random(200);
        wait_drained();

        // Let any stray beat show up before judging.
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0 && due_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/rbd_pkg.sv
design/rbd_cell.sv
design/rbd_rear_sel.sv
design/ring_buffer_deque.sv
verif/tb_top.sv
